// ===== design/qsa_pkg.sv =====
`default_nettype none

package qsa_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int SUM_BITS           = 8;
    localparam int MIN_INTERVAL_BITS  = 16;
    localparam int TICK_BITS          = 32;
    localparam logic [MIN_INTERVAL_BITS-1:0] MIN_INTERVAL_RESET = 16'd2;

    // Accumulator saturation bound, symmetric
    localparam logic signed [SUM_BITS-1:0] SUM_LIMIT = 8'sd127;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    typedef enum logic [1:0] {
        EVENT_NONE  = 2'd0,
        EVENT_RIGHT = 2'd1,
        EVENT_LEFT  = 2'd2
    } event_t;

    typedef struct packed {
        logic                 op;
        logic [1:0]           pins;         // {A, B}
        logic [1:0]           pins_second;  // {A, B}, edge items only
        logic [TICK_BITS-1:0] now_tick;
    } qsa_item_t;

    typedef struct packed {
        event_t event_res;
        logic   sample_dropped;
    } qsa_status_t;

    // Half-step table indexed by {previous pins, new pins}; +1, -1 or 0
    function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = 2'sb01;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sb11;
            default:                  d = 2'sb00;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/quadrature_step_accumulator.sv =====
// Quadrature decoder (x2) with half-step accumulation and rate-limited
// counter updates.
// Input stream (s_*): one transfer per item. tuser[0] selects the kind:
// 0 = pin edge with two samples (dropped if they disagree), 1 = poll with the
// current pins and a timestamp. A poll may move whole steps from the half-step
// accumulator into the right or left counter once min_interval_ticks have
// passed since the last update.
// Output stream (m_*): exactly one result transfer per input transfer, in
// order: both counters, their difference, the event code and the drop flag.
// Configuration: cfg_we/cfg_wdata write min_interval_ticks; write only while
// no item is in flight.
// m_tvalid rises for an item once it has passed the input register, then the
// result register. Throughput: one item per cycle while m_tready is high; the
// combinational decode/saturate/compare path feeding the state registers
// sustains this rate.
// Reset clears decoder state, counters and both pipeline stages and loads
// min_interval_ticks = 2. When m_tready is low the result holds, the input
// register fills and s_tready drops; nothing is lost.
`default_nettype none

module quadrature_step_accumulator #(
    parameter int COUNT_BITS = qsa_pkg::COUNT_BITS_DEFAULT
) (
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    // configuration
    input  wire  logic        cfg_we,
    input  wire  logic [15:0] cfg_wdata,   // min_interval_ticks
    // input stream
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [39:0] s_tdata,     // pin_a, pin_b, pin_a_second, pin_b_second,
                                           // now_tick[31:0], 4'b0
    input  wire  logic [0:0]  s_tuser,     // op
    // result stream
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [95:0]       m_tdata,     // right_count, left_count, difference
    output logic [2:0]        m_tuser      // event_res[1:0], sample_dropped
);

    // input stage
    logic               in_valid_reg;
    qsa_pkg::qsa_item_t in_item_reg;
    logic               advance;

    // result stage
    logic               out_valid_reg;
    logic [95:0]        out_data_reg;
    logic [2:0]         out_user_reg;

    logic [COUNT_BITS-1:0] positive_next, negative_next;
    qsa_pkg::qsa_status_t  status;
    logic [63:0]           positive_wide, negative_wide;
    logic [31:0]           right_count, left_count;

    // the result register frees up when empty or being taken this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op          <= s_tuser[0];
            in_item_reg.pins        <= {s_tdata[0], s_tdata[1]};
            in_item_reg.pins_second <= {s_tdata[2], s_tdata[3]};
            in_item_reg.now_tick    <= s_tdata[35:4];
        end
    end

    qsa_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .item_en       (advance),
        .item          (in_item_reg),
        .positive_next (positive_next),
        .negative_next (negative_next),
        .status        (status)
    );

    // outputs show the low 32 bits of the totals
    assign positive_wide = 64'(positive_next);
    assign negative_wide = 64'(negative_next);
    assign right_count   = positive_wide[31:0];
    assign left_count    = negative_wide[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {right_count - left_count, left_count, right_count};
            out_user_reg <= {status.sample_dropped, status.event_res};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// ===== design/qsa_tracker.sv =====
`default_nettype none

module qsa_tracker #(
    parameter int COUNT_BITS = qsa_pkg::COUNT_BITS_DEFAULT
) (
    input  wire  logic                                   clk,
    input  wire  logic                                   rst_n,
    input  wire  logic                                   cfg_we,
    input  wire  logic [qsa_pkg::MIN_INTERVAL_BITS-1:0]  cfg_wdata,
    input  wire  logic                                   item_en,
    input  wire  qsa_pkg::qsa_item_t                     item,
    output logic [COUNT_BITS-1:0]                        positive_next,
    output logic [COUNT_BITS-1:0]                        negative_next,
    output qsa_pkg::qsa_status_t                         status
);

    localparam int SB = qsa_pkg::SUM_BITS;

    logic [qsa_pkg::MIN_INTERVAL_BITS-1:0] min_interval_reg;
    logic [1:0]                            prev_pins_reg, prev_pins_next;
    logic signed [SB-1:0]                  sum_reg, sum_next;
    logic [qsa_pkg::TICK_BITS-1:0]         last_time_reg, last_time_next;
    logic [COUNT_BITS-1:0]                 positive_reg, negative_reg;

    logic signed [1:0]             d;
    logic                          match;
    logic                          apply;
    logic signed [SB:0]            sum_wide;
    logic signed [SB-1:0]          sum_applied;
    logic                          neg;
    logic [SB-1:0]                 abs_sum;
    logic [SB-3:0]                 mag;
    logic signed [SB-1:0]          rem;
    logic [qsa_pkg::TICK_BITS-1:0] elapsed;
    logic                          update;

    always_comb
    begin
        d     = qsa_pkg::step_lookup({prev_pins_reg, item.pins});
        match = (item.pins == item.pins_second);
        apply = (item.op == qsa_pkg::OP_EDGE) ? match : (d != 2'sb00);

        // saturating half-step add
        sum_wide = {sum_reg[SB-1], sum_reg} + {{(SB-1){d[1]}}, d};
        if (sum_wide > (SB+1)'(qsa_pkg::SUM_LIMIT))
            sum_applied = qsa_pkg::SUM_LIMIT;
        else if (sum_wide < -(SB+1)'(qsa_pkg::SUM_LIMIT))
            sum_applied = -qsa_pkg::SUM_LIMIT;
        else
            sum_applied = sum_wide[SB-1:0];
        if (!apply)
            sum_applied = sum_reg;

        // truncating divide by two: magnitude halved, sign kept in remainder
        neg     = sum_applied[SB-1];
        abs_sum = neg ? -sum_applied : sum_applied;
        mag     = abs_sum[SB-2:1];
        rem     = !sum_applied[0] ? '0 : (neg ? -(SB'(1)) : SB'(1));

        elapsed = item.now_tick - last_time_reg;
        update  = (item.op == qsa_pkg::OP_POLL) && (sum_applied != '0)
                  && (elapsed >= qsa_pkg::TICK_BITS'(min_interval_reg)) && (mag != '0);

        prev_pins_next = apply ? item.pins : prev_pins_reg;
        sum_next       = update ? rem : sum_applied;
        last_time_next = update ? item.now_tick : last_time_reg;
        positive_next  = positive_reg;
        negative_next  = negative_reg;
        status.event_res      = qsa_pkg::EVENT_NONE;
        status.sample_dropped = (item.op == qsa_pkg::OP_EDGE) && !match;
        if (update)
        begin
            if (neg)
            begin
                negative_next    = negative_reg + {{(COUNT_BITS-SB+2){1'b0}}, mag};
                status.event_res = qsa_pkg::EVENT_LEFT;
            end
            else
            begin
                positive_next    = positive_reg + {{(COUNT_BITS-SB+2){1'b0}}, mag};
                status.event_res = qsa_pkg::EVENT_RIGHT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= qsa_pkg::MIN_INTERVAL_RESET;
            prev_pins_reg    <= '0;
            sum_reg          <= '0;
            last_time_reg    <= '0;
            positive_reg     <= '0;
            negative_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                min_interval_reg <= cfg_wdata;
            if (item_en)
            begin
                prev_pins_reg <= prev_pins_next;
                sum_reg       <= sum_next;
                last_time_reg <= last_time_next;
                positive_reg  <= positive_next;
                negative_reg  <= negative_next;
            end
        end
    end

`ifndef SYNTH
    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg != {1'b1, {(SB-1){1'b0}}})
        else $error("half-step sum outside saturation bound");

    a_drop_keeps_pins: assert property (@(posedge clk) disable iff (!rst_n)
        item_en && status.sample_dropped |=> $stable(prev_pins_reg) && $stable(sum_reg))
        else $error("dropped sample changed decoder state");

    a_event_leaves_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        item_en && status.event_res != qsa_pkg::EVENT_NONE
        |=> sum_reg == '0 || sum_reg == SB'(1) || sum_reg == -(SB'(1)))
        else $error("counter update left more than a half step");

    a_right_counts: assert property (@(posedge clk) disable iff (!rst_n)
        item_en && status.event_res == qsa_pkg::EVENT_RIGHT
        |=> positive_reg != $past(positive_reg) && $stable(negative_reg))
        else $error("right event without right count change");
`endif

endmodule

`default_nettype wire
